// ----- src/srcu_pkg.sv -----
package srcu_pkg;

  localparam int TOL_W = 16;
  localparam int CFG_IDX_W = 3;
  localparam longint RECT_MAX_RESET = 65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_X = 3'd0,
    REG_MAX_X = 3'd1,
    REG_MIN_Y = 3'd2,
    REG_MAX_Y = 3'd3,
    REG_TOL   = 3'd4
  } cfg_reg_e;

endpackage

// ----- src/segment_rectangle_clipper_unit.sv -----
// Throughput: one segment per cycle; the four crossing dividers are pipelined
// one quotient bit per stage, COORD_BITS stages deep.
// The whole pipeline holds while a result waits on a stalled output.
// Reset: asynchronous, active low; clears all valid bits and loads the
// rectangle registers with their default bounds and tolerance 0.
module segment_rectangle_clipper_unit #(
  parameter int COORD_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [srcu_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [COORD_BITS-1:0]         cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [COORD_BITS-1:0]  first_x_i,
  input  logic signed [COORD_BITS-1:0]  first_y_i,
  input  logic signed [COORD_BITS-1:0]  second_x_i,
  input  logic signed [COORD_BITS-1:0]  second_y_i,
  input  logic                          ends_defined_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          hit_o,
  output logic                          left_valid_o,
  output logic signed [COORD_BITS-1:0]  left_x_o,
  output logic signed [COORD_BITS-1:0]  left_y_o,
  output logic                          right_valid_o,
  output logic signed [COORD_BITS-1:0]  right_x_o,
  output logic signed [COORD_BITS-1:0]  right_y_o
);

  localparam int CW = COORD_BITS;
  localparam int DW = CW + 1;
  localparam int EW = CW + 2;
  localparam int PW = 2 * CW;

  typedef logic signed [CW-1:0] crd_t;
  typedef struct packed {
    crd_t x;
    crd_t y;
  } pt_t;

  typedef struct packed {
    logic          ends;
    pt_t           l;
    pt_t           r;
    logic          in_l;
    logic          in_r;
    logic          horiz;
    logic          vert;
    logic          hv_hit;
    logic [3:0]    pre_ok;
    logic [CW-1:0] dxm;
  } side_t;

  typedef struct packed {
    logic          neg;
    logic [CW-1:0] am;
    logic [CW-1:0] mm;
    logic [CW-1:0] d;
  } op_t;

  typedef struct packed {
    logic          neg;
    logic [CW-1:0] d;
    logic [PW-1:0] prod;
  } mul_t;

  typedef struct packed {
    logic          neg;
    logic          sat;
    logic [CW-1:0] d;
    logic [CW:0]   rem;
    logic [CW-1:0] lo;
    logic [CW-1:0] q;
  } dv_t;

  typedef struct packed {
    logic hit;
    logic ord;
    logic lv;
    logic rv;
    pt_t  lp;
    pt_t  rp;
  } res_t;

  // configuration
  crd_t                      min_x_q, max_x_q, min_y_q, max_y_q;
  logic [srcu_pkg::TOL_W-1:0] tol_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_x_q <= '0;
      max_x_q <= CW'(srcu_pkg::RECT_MAX_RESET);
      min_y_q <= '0;
      max_y_q <= CW'(srcu_pkg::RECT_MAX_RESET);
      tol_q   <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        srcu_pkg::REG_MIN_X: min_x_q <= cfg_data_i;
        srcu_pkg::REG_MAX_X: max_x_q <= cfg_data_i;
        srcu_pkg::REG_MIN_Y: min_y_q <= cfg_data_i;
        srcu_pkg::REG_MAX_Y: max_y_q <= cfg_data_i;
        srcu_pkg::REG_TOL:   tol_q   <= cfg_data_i[srcu_pkg::TOL_W-1:0];
        default: ;
      endcase
    end
  end

  logic adv;
  assign adv        = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;

  function automatic logic inside_f(pt_t p, crd_t x0, crd_t x1, crd_t y0, crd_t y1);
    inside_f = (p.x >= x0) && (p.x < x1) && (p.y >= y0) && (p.y < y1);
  endfunction

  // stage 1: order endpoints
  logic v1_q;
  logic ends1_q;
  pt_t  l1_q, r1_q;
  pt_t  pa, pb;
  logic swap_in;

  always_comb begin
    pa.x = first_x_i;
    pa.y = first_y_i;
    pb.x = second_x_i;
    pb.y = second_y_i;
    swap_in = (pa.x > pb.x) || ((pa.x == pb.x) && (pa.y > pb.y));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (adv) v1_q <= in_valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ends1_q <= ends_defined_i;
      l1_q    <= swap_in ? pb : pa;
      r1_q    <= swap_in ? pa : pb;
    end
  end

  // stage 2: differences, border offsets, inside and tolerance tests
  logic  v2_q;
  side_t s2_q, s2_d;
  op_t   op2_q [4];
  op_t   op2_d [4];

  always_comb begin
    logic signed [DW-1:0] dx, dy, dl;
    logic signed [DW-1:0] a;
    logic [DW-1:0]        dym, dlm;
    logic [DW-1:0]        am;
    crd_t                 bnd [4];
    crd_t                 base;
    bnd[0] = min_x_q;
    bnd[1] = max_x_q;
    bnd[2] = min_y_q;
    bnd[3] = max_y_q;
    dx  = DW'(r1_q.x) - DW'(l1_q.x);
    dy  = DW'(r1_q.y) - DW'(l1_q.y);
    dym = dy[DW-1] ? DW'(-dy) : DW'(dy);
    dl  = DW'(l1_q.x) - DW'(r1_q.x);
    dlm = dl[DW-1] ? DW'(-dl) : DW'(dl);
    s2_d.ends  = ends1_q;
    s2_d.l     = l1_q;
    s2_d.r     = r1_q;
    s2_d.in_l  = inside_f(l1_q, min_x_q, max_x_q, min_y_q, max_y_q);
    s2_d.in_r  = inside_f(r1_q, min_x_q, max_x_q, min_y_q, max_y_q);
    s2_d.horiz = dym <= DW'(tol_q);
    s2_d.vert  = dlm <= DW'(tol_q);
    s2_d.hv_hit =
      (s2_d.horiz && (l1_q.x < min_x_q) && (r1_q.x >= max_x_q) &&
       (l1_q.y >= min_y_q) && (l1_q.y < max_y_q)) ||
      (s2_d.vert && (l1_q.x >= min_x_q) && (l1_q.x < max_x_q) &&
       (l1_q.y < min_y_q) && (r1_q.y >= max_y_q));
    s2_d.dxm = dx[CW-1:0];
    for (int k = 0; k < 4; k++) begin
      base = (k < 2) ? l1_q.x : l1_q.y;
      a  = DW'(bnd[k]) - DW'(base);
      am = a[DW-1] ? DW'(-a) : DW'(a);
      op2_d[k].neg = a[DW-1] ^ dy[DW-1];
      op2_d[k].am  = am[CW-1:0];
      op2_d[k].mm  = (k < 2) ? dym[CW-1:0] : dx[CW-1:0];
      op2_d[k].d   = (k < 2) ? dx[CW-1:0] : dym[CW-1:0];
      if (k < 2) begin
        s2_d.pre_ok[k] = (l1_q.x <= bnd[k]) && (bnd[k] <= r1_q.x) && (dx != '0);
      end else begin
        s2_d.pre_ok[k] = (dx != '0) && (dy != '0);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (adv) v2_q <= v1_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_q <= s2_d;
      for (int k = 0; k < 4; k++) op2_q[k] <= op2_d[k];
    end
  end

  // stage 3: products
  logic  v3_q;
  side_t s3_q;
  mul_t  m3_q [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else if (adv) v3_q <= v2_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_q <= s2_q;
      for (int k = 0; k < 4; k++) begin
        m3_q[k].neg  <= op2_q[k].neg;
        m3_q[k].d    <= op2_q[k].d;
        m3_q[k].prod <= PW'(op2_q[k].am) * PW'(op2_q[k].mm);
      end
    end
  end

  // divider stages: stage 0 loads the high half, then one quotient bit per stage
  logic  vd_q [CW+1];
  side_t sd_q [CW+1];
  dv_t   dv_q [CW+1][4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vd_q[0] <= 1'b0;
    else if (adv) vd_q[0] <= v3_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sd_q[0] <= s3_q;
      for (int k = 0; k < 4; k++) begin
        dv_q[0][k].neg <= m3_q[k].neg;
        dv_q[0][k].d   <= m3_q[k].d;
        dv_q[0][k].sat <= m3_q[k].prod[PW-1:CW] >= m3_q[k].d;
        dv_q[0][k].rem <= {1'b0, m3_q[k].prod[PW-1:CW]};
        dv_q[0][k].lo  <= m3_q[k].prod[CW-1:0];
        dv_q[0][k].q   <= '0;
      end
    end
  end

  for (genvar j = 1; j <= CW; j++) begin : g_div
    dv_t dv_d [4];

    always_comb begin
      logic [CW:0] t;
      logic        bit_q;
      for (int k = 0; k < 4; k++) begin
        t     = {dv_q[j-1][k].rem[CW-1:0], dv_q[j-1][k].lo[CW-1]};
        bit_q = t >= {1'b0, dv_q[j-1][k].d};
        dv_d[k]     = dv_q[j-1][k];
        dv_d[k].rem = bit_q ? (t - {1'b0, dv_q[j-1][k].d}) : t;
        dv_d[k].lo  = {dv_q[j-1][k].lo[CW-2:0], 1'b0};
        dv_d[k].q   = {dv_q[j-1][k].q[CW-2:0], bit_q};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) vd_q[j] <= 1'b0;
      else if (adv) vd_q[j] <= vd_q[j-1];
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        sd_q[j] <= sd_q[j-1];
        for (int k = 0; k < 4; k++) dv_q[j][k] <= dv_d[k];
      end
    end
  end

  // stage 4: crossing points and their acceptance
  logic       v4_q;
  side_t      s4_q;
  logic [3:0] ok4_q, ok4_d;
  pt_t        pt4_q [4];
  pt_t        pt4_d [4];

  always_comb begin
    logic signed [EW-1:0] qs, c, lo0, hi0;
    side_t                sd;
    crd_t                 bnd [4];
    sd = sd_q[CW];
    bnd[0] = min_x_q;
    bnd[1] = max_x_q;
    bnd[2] = min_y_q;
    bnd[3] = max_y_q;
    for (int k = 0; k < 4; k++) begin
      qs = dv_q[CW][k].neg ? -EW'({1'b0, dv_q[CW][k].q}) : EW'({1'b0, dv_q[CW][k].q});
      if (k < 2) begin
        c   = EW'(sd.l.y) + qs;
        lo0 = EW'(min_y_q);
        hi0 = EW'(max_y_q);
        ok4_d[k] = sd.pre_ok[k] && !dv_q[CW][k].sat && (c >= lo0) && (c < hi0);
        pt4_d[k].x = bnd[k];
        pt4_d[k].y = c[CW-1:0];
      end else begin
        c   = EW'(sd.l.x) + qs;
        lo0 = EW'(min_x_q);
        hi0 = EW'(max_x_q);
        ok4_d[k] = sd.pre_ok[k] && !dv_q[CW][k].sat &&
                   !(dv_q[CW][k].neg && (dv_q[CW][k].q != '0)) &&
                   (dv_q[CW][k].q <= sd.dxm) && (c >= lo0) && (c < hi0);
        pt4_d[k].x = c[CW-1:0];
        pt4_d[k].y = bnd[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v4_q <= 1'b0;
    else if (adv) v4_q <= vd_q[CW];
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s4_q  <= sd_q[CW];
      ok4_q <= ok4_d;
      for (int k = 0; k < 4; k++) pt4_q[k] <= pt4_d[k];
    end
  end

  // stage 5: hit decision and point selection
  logic v5_q;
  res_t r5_q, r5_d;

  always_comb begin
    logic two, one;
    two  = s4_q.in_l && s4_q.in_r;
    one  = s4_q.in_l ^ s4_q.in_r;
    r5_d = '0;
    r5_d.hit = s4_q.ends && (s4_q.in_l || s4_q.in_r || s4_q.hv_hit || (ok4_q != '0));
    if (r5_d.hit) begin
      if (two || s4_q.horiz || s4_q.vert) begin
        r5_d.lv = 1'b1;
        r5_d.rv = 1'b1;
        r5_d.lp = s4_q.l;
        r5_d.rp = s4_q.r;
        if (!two && s4_q.horiz) begin
          if (s4_q.l.x < min_x_q) r5_d.lp.x = min_x_q;
          if (s4_q.r.x > max_x_q) r5_d.rp.x = max_x_q;
        end else if (!two) begin
          if (s4_q.l.y < min_y_q) r5_d.lp.y = min_y_q;
          if (s4_q.r.y > max_y_q) r5_d.rp.y = max_y_q;
        end
      end else begin
        // only results built from crossings (with any inside endpoint) get reordered
        r5_d.ord = 1'b1;
        if (one) begin
          r5_d.lp = s4_q.in_l ? s4_q.l : s4_q.r;
          r5_d.lv = 1'b1;
        end
        for (int k = 0; k < 4; k++) begin
          if (!r5_d.rv && ok4_q[k]) begin
            if (!r5_d.lv) begin
              r5_d.lp = pt4_q[k];
              r5_d.lv = 1'b1;
            end else begin
              r5_d.rp = pt4_q[k];
              r5_d.rv = 1'b1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v5_q <= 1'b0;
    else if (adv) v5_q <= v4_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) r5_q <= r5_d;
  end

  // output register: order the two points and drop undefined ones
  logic out_valid_q;
  res_t ro_q, ro_d;

  always_comb begin
    logic sw;
    ro_d = r5_q;
    sw = r5_q.ord && r5_q.lv && r5_q.rv &&
         ((r5_q.lp.x > r5_q.rp.x) || ((r5_q.lp.x == r5_q.rp.x) && (r5_q.lp.y > r5_q.rp.y)));
    if (sw) begin
      ro_d.lp = r5_q.rp;
      ro_d.rp = r5_q.lp;
    end
    if (!r5_q.lv) ro_d.lp = '0;
    if (!r5_q.rv) ro_d.rp = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (adv) out_valid_q <= v5_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) ro_q <= ro_d;
  end

  assign out_valid_o   = out_valid_q;
  assign hit_o         = ro_q.hit;
  assign left_valid_o  = ro_q.lv;
  assign left_x_o      = ro_q.lp.x;
  assign left_y_o      = ro_q.lp.y;
  assign right_valid_o = ro_q.rv;
  assign right_x_o     = ro_q.rp.x;
  assign right_y_o     = ro_q.rp.y;

endmodule

// ----- src/srcu_checker.sv -----
module srcu_checker #(
  parameter int COORD_BITS = 32
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_ready_o,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input logic                  hit_o,
  input logic                  left_valid_o,
  input logic [COORD_BITS-1:0] left_x_o,
  input logic [COORD_BITS-1:0] left_y_o,
  input logic                  right_valid_o,
  input logic [COORD_BITS-1:0] right_x_o,
  input logic [COORD_BITS-1:0] right_y_o
);

  // a stalled result word stays valid and keeps left_x and right_y
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(left_x_o) && $stable(right_y_o))
    else $error("stalled result word changed");

  a_no_hit_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !hit_o |-> !left_valid_o && !right_valid_o &&
      left_x_o == '0 && left_y_o == '0 && right_x_o == '0 && right_y_o == '0)
    else $error("miss carries point data");

  a_hit_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (hit_o == left_valid_o))
    else $error("hit without left point");

  a_right_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && right_valid_o |-> left_valid_o)
    else $error("right point without left point");

  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output");

endmodule

bind segment_rectangle_clipper_unit srcu_checker #(.COORD_BITS(COORD_BITS)) u_srcu_checker (
  .clk_i(clk_i),
  .rst_ni(rst_ni),
  .in_ready_o(in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .hit_o(hit_o),
  .left_valid_o(left_valid_o),
  .left_x_o(left_x_o),
  .left_y_o(left_y_o),
  .right_valid_o(right_valid_o),
  .right_x_o(right_x_o),
  .right_y_o(right_y_o)
);

// ----- tb/tb.sv -----
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW = 32;
  localparam longint SAT = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam int LIMIT = 400000;

  typedef struct packed {
    bit hit;
    bit lv;
    logic signed [CW-1:0] lx, ly;
    bit rv;
    logic signed [CW-1:0] rx, ry;
  } clip_t;

  typedef struct {
    longint x;
    longint y;
  } pt_t;

  // rectangle and tolerance as the block should hold them
  longint bx0, bx1, by0, by1, tol;

  function automatic longint iabs(longint v);
    return v < 0 ? -v : v;
  endfunction

  // trunc(a*b/d), saturating; products stay below 2^100 so 128 bits suffice
  function automatic longint scale(longint a, longint b, longint d);
    logic signed [127:0] p, q;
    p = 128'(a) * 128'(b);
    q = p / 128'(d);
    if (q > 128'(SAT)) return SAT;
    if (q < -128'(SAT)) return -SAT;
    return longint'(q);
  endfunction

  function automatic bit in_rect(pt_t p);
    return p.x >= bx0 && p.x < bx1 && p.y >= by0 && p.y < by1;
  endfunction

  // crossing on border k: left, right, lower, upper
  function automatic bit border_cross(int k, pt_t l, pt_t r, output pt_t o);
    longint dx, dy, b, y, q, x;
    dx = r.x - l.x;
    dy = r.y - l.y;
    o = '{0, 0};
    if (dx == 0) return 0;
    if (k < 2) begin
      b = (k == 0) ? bx0 : bx1;
      if (!(l.x <= b && b <= r.x)) return 0;
      y = l.y + scale(b - l.x, dy, dx);
      if (y < by0 || y >= by1) return 0;
      o = '{b, y};
      return 1;
    end
    if (dy == 0) return 0;
    b = (k == 2) ? by0 : by1;
    q = scale(b - l.y, dx, dy);
    if (q < 0 || q > dx) return 0;
    x = l.x + q;
    if (x < bx0 || x >= bx1) return 0;
    o = '{x, b};
    return 1;
  endfunction

  function automatic clip_t clip_segment(logic signed [CW-1:0] ax, ay, cx, cy, bit def);
    clip_t res;
    pt_t a, c, l, r, lp, rp, t;
    bit lv, rv, hit, horiz, vert;
    int cnt;
    res = '{0, 0, 0, 0, 0, 0, 0};
    if (!def) return res;
    a = '{longint'(ax), longint'(ay)};
    c = '{longint'(cx), longint'(cy)};
    if (a.x > c.x || (a.x == c.x && a.y > c.y)) begin
      l = c; r = a;
    end else begin
      l = a; r = c;
    end
    cnt = int'(in_rect(l)) + int'(in_rect(r));
    horiz = iabs(l.y - r.y) <= tol;
    vert = iabs(l.x - r.x) <= tol;
    hit = cnt > 0;
    if (!hit) begin
      if (horiz && l.x < bx0 && r.x >= bx1 && l.y >= by0 && l.y < by1) hit = 1;
      if (vert && l.x >= bx0 && l.x < bx1 && l.y < by0 && r.y >= by1) hit = 1;
      for (int k = 0; k < 4 && !hit; k++)
        if (border_cross(k, l, r, t)) hit = 1;
    end
    if (!hit) return res;
    lp = l; rp = r; lv = 1; rv = 1;
    if (cnt < 2) begin
      if (horiz) begin
        if (lp.x < bx0) lp.x = bx0;
        if (rp.x > bx1) rp.x = bx1;
      end else if (vert) begin
        if (lp.y < by0) lp.y = by0;
        if (rp.y > by1) rp.y = by1;
      end else begin
        lv = 0; rv = 0;
        if (cnt == 1) begin
          lp = in_rect(l) ? l : r;
          lv = 1;
        end
        for (int k = 0; k < 4; k++)
          if (!rv && border_cross(k, l, r, t)) begin
            if (!lv) begin
              lp = t; lv = 1;
            end else begin
              rp = t; rv = 1;
            end
          end
        if (lv && rv && (lp.x > rp.x || (lp.x == rp.x && lp.y > rp.y))) begin
          t = lp; lp = rp; rp = t;
        end
        if (!lv) lp = '{0, 0};
        if (!rv) rp = '{0, 0};
      end
    end
    res = '{1, lv, CW'(lp.x), CW'(lp.y), rv, CW'(rp.x), CW'(rp.y)};
    return res;
  endfunction

  class clip_scoreboard;
    clip_t pending[$];
    int errors;

    function void note_segment(clip_t c);
      pending.push_back(c);
    endfunction

    function void check_result(clip_t got);
      clip_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result word hit=%0b", got.hit);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10) begin
          $write("mismatch exp hit=%0b l=%0b(%0d,%0d) r=%0b(%0d,%0d)",
                 want.hit, want.lv, want.lx, want.ly, want.rv, want.rx, want.ry);
          $display(" got hit=%0b l=%0b(%0d,%0d) r=%0b(%0d,%0d)",
                   got.hit, got.lv, got.lx, got.ly, got.rv, got.rx, got.ry);
        end
      end
    endfunction
  endclass

  logic clk_i = 0, rst_ni = 0;
  logic cfg_valid_i = 0, cfg_ready_o;
  logic [srcu_pkg::CFG_IDX_W-1:0] cfg_index_i = srcu_pkg::REG_MIN_X;
  logic [CW-1:0] cfg_data_i = '0;
  logic in_valid_i = 0, in_ready_o;
  logic signed [CW-1:0] first_x_i = '0, first_y_i = '0, second_x_i = '0, second_y_i = '0;
  logic ends_defined_i = 0;
  logic out_valid_o, out_ready_i = 0;
  logic hit_o, left_valid_o, right_valid_o;
  logic signed [CW-1:0] left_x_o, left_y_o, right_x_o, right_y_o;

  segment_rectangle_clipper_unit #(.COORD_BITS(CW)) u_top (.*);

  always #5 clk_i = ~clk_i;

  clip_scoreboard sb = new();
  bit hold_off = 0;
  int cycles = 0;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // receiver: own stall pattern, plus a long hold-off on request
  initial begin
    int mode;
    mode = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i)
        sb.check_result('{hit_o, left_valid_o, left_x_o, left_y_o,
                          right_valid_o, right_x_o, right_y_o});
      if (cycles % 200 == 0) mode = $urandom_range(0, 2);
      if (hold_off) out_ready_i <= 0;
      else if (mode == 0) out_ready_i <= 1;
      else if (mode == 1) out_ready_i <= ($urandom_range(0, 3) != 0);
      else out_ready_i <= ($urandom_range(0, 3) == 0);
    end
  end

  // valid stays high between back-to-back writes; set_rect drops it at the end
  task automatic write_reg(srcu_pkg::cfg_reg_e idx, logic [CW-1:0] val);
    cfg_valid_i <= 1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      srcu_pkg::REG_MIN_X: bx0 = longint'($signed(val));
      srcu_pkg::REG_MAX_X: bx1 = longint'($signed(val));
      srcu_pkg::REG_MIN_Y: by0 = longint'($signed(val));
      srcu_pkg::REG_MAX_Y: by1 = longint'($signed(val));
      default: tol = longint'(val[srcu_pkg::TOL_W-1:0]);
    endcase
  endtask

  task automatic set_rect(longint x0, x1, y0, y1, t);
    write_reg(srcu_pkg::REG_MIN_X, CW'(x0));
    write_reg(srcu_pkg::REG_MAX_X, CW'(x1));
    write_reg(srcu_pkg::REG_MIN_Y, CW'(y0));
    write_reg(srcu_pkg::REG_MAX_Y, CW'(y1));
    write_reg(srcu_pkg::REG_TOL, CW'(t));
    cfg_valid_i <= 0;
  endtask

  int gap_left = 0;

  // offer one word, with random bursts and gaps before it
  task automatic send_segment(logic signed [CW-1:0] ax, ay, cx, cy, bit def);
    if (gap_left == 0 && $urandom_range(0, 9) == 0) gap_left = -int'($urandom_range(1, 8));
    if (gap_left < 0) in_valid_i <= 0;
    while (gap_left < 0) begin
      @(posedge clk_i);
      gap_left++;
    end
    in_valid_i <= 1;
    first_x_i <= ax;
    first_y_i <= ay;
    second_x_i <= cx;
    second_y_i <= cy;
    ends_defined_i <= def;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_segment(clip_segment(ax, ay, cx, cy, def));
  endtask

  task automatic drain();
    in_valid_i <= 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  // coordinate near the rectangle, sometimes anywhere
  function automatic logic signed [CW-1:0] near(longint lo, longint hi);
    longint span;
    if ($urandom_range(0, 7) == 0) return $urandom;
    span = hi - lo;
    if (span < 4) span = 4;
    return CW'(lo - span / 2 + longint'($urandom_range(0, 1023)) * (span * 2) / 1023);
  endfunction

  task automatic random_phase(int n);
    logic signed [CW-1:0] ax, ay, cx, cy;
    for (int i = 0; i < n; i++) begin
      ax = near(bx0, bx1);
      ay = near(by0, by1);
      cx = near(bx0, bx1);
      cy = near(by0, by1);
      case ($urandom_range(0, 5))
        0: cy = ay + CW'($urandom_range(0, int'(2 * tol + 1))) - CW'(tol);
        1: cx = ax + CW'($urandom_range(0, int'(2 * tol + 1))) - CW'(tol);
        2: cx = ax;
        default: ;
      endcase
      send_segment(ax, ay, cx, cy, $urandom_range(0, 9) != 0);
    end
  endtask

  localparam logic signed [CW-1:0] MAXC = 32'sh7FFF_FFFF;
  localparam logic signed [CW-1:0] MINC = 32'sh8000_0000;

  initial begin
    bx0 = 0; bx1 = 65536; by0 = 0; by1 = 65536; tol = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: reset rectangle
    send_segment(100, 100, 200, 200, 1);
    send_segment(100, 100, 200, 200, 0);
    send_segment(-100, 300, 70000, 300, 1);
    send_segment(300, -100, 300, 70000, 1);
    send_segment(-1000, -500, 70000, 60000, 1);
    send_segment(70000, 70000, -1000, -1000, 1);
    send_segment(-5000, 40000, 40000, 80000, 1);
    send_segment(-10, 70000, -10, 80000, 1);
    send_segment(100, 5, 200, 5, 1);
    send_segment(500, 500, 500, 400, 1);
    send_segment(MINC, MINC, MAXC, MAXC, 1);
    send_segment(MAXC, MINC, MINC, MAXC, 1);
    send_segment(MINC, 0, MAXC, 1, 1);
    send_segment(0, 65536, 65536, 0, 1);
    send_segment(65536, 65536, 65536, 65536, 1);
    send_segment(-1, -1, -1, -1, 1);
    drain();
    set_rect(-65536, 131072, -32768, 98304, 16);
    send_segment(-100000, 10, 200000, 20, 1);
    send_segment(10, -100000, 20, 200000, 1);
    send_segment(MINC, MAXC, MAXC, MINC, 1);
    drain();
    set_rect(MINC, MAXC, MINC, MAXC, 65535);
    send_segment(MINC, MINC, MAXC, MAXC, 1);
    send_segment(0, MINC, 60000, MAXC, 1);
    drain();
    // inverted rectangle
    set_rect(1000, -1000, 1000, -1000, 0);
    send_segment(-2000, -2000, 2000, 2000, 1);
    send_segment(-2000, 5, 2000, 5, 1);
    drain();

    set_rect(0, 65536, 0, 65536, 0);
    random_phase(120);
    // hold off the receiver while words keep coming
    fork
      begin
        hold_off = 1;
        repeat (300) @(posedge clk_i);
        hold_off = 0;
      end
      random_phase(90);
    join
    drain();
    set_rect(-1 << 20, 1 << 22, -3 << 18, 5 << 19, 300);
    random_phase(120);
    drain();
    set_rect(MINC, MAXC, -100, 100, 65535);
    random_phase(60);
    drain();
    set_rect($signed($urandom), $signed($urandom), $signed($urandom), $signed($urandom),
             $urandom_range(0, 65535));
    random_phase(60);
    drain();

    if (sb.errors == 0 && sb.pending.size() == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule
